>>> src/rpdf_pkg.sv
// Shared types and constants for the recent packet duplicate filter.
// No dependencies; used by rpdf_store and recent_packet_duplicate_filter.
package rpdf_pkg;

  localparam int unsigned NOW_W      = 32;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned STAMP_W    = 16;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned HELD_OUT_W = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE    = 2'd2;

  // configuration reset values
  localparam logic [ID_W-1:0]  SELF_ID_RST = 8'd0;
  localparam logic [ID_W-1:0]  BCAST_RST   = 8'd255;
  localparam logic [GAP_W-1:0] EXPIRE_RST  = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_LOCATE,
    ST_SCAN,
    ST_STORE,
    ST_RESULT
  } rpdf_state_e;

endpackage

>>> src/rpdf_store.sv
// Entry store of the duplicate filter: one write port, one registered read port.
// Depends on rpdf_pkg for the entry width.
module rpdf_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [IDX_W-1:0]            wr_addr_i,
  input  logic [rpdf_pkg::KEY_W-1:0]  wr_data_i,
  input  logic                        rd_en_i,
  input  logic [IDX_W-1:0]            rd_addr_i,
  output logic [rpdf_pkg::KEY_W-1:0]  rd_data_o
);

  logic [rpdf_pkg::KEY_W-1:0] mem_q [DEPTH];
  logic [rpdf_pkg::KEY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/recent_packet_duplicate_filter.sv
// Top level of the recent packet duplicate filter: sequencer, gap rule, ring scan.
// Depends on rpdf_pkg and rpdf_store.
//
//   channel   signals                                    direction
//   ------    -----------------------------------------  ---------
//   cfg       cfg_we_i, cfg_idx_i, cfg_data_i             in (write only)
//   in        in_valid_i/in_stall_o + header fields       in
//   out       out_valid_o/out_stall_i + result flags      out
//
// An accepted header steps through gap, locate, scan, store, result and back to idle;
// the scan reads each entry held after the gap rule, oldest first, and compares the
// registered read data with the key. A header not for this node skips scan and store;
// an empty ring skips the scan; a hit ends the scan early. Reset clears control state and
// config registers; the store is not cleared, only written slots are ever read. The result
// sits in an output register, so the next transaction is taken while it waits; a stalled result holds RESULT.
module recent_packet_duplicate_filter #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [rpdf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rpdf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rpdf_pkg::NOW_W-1:0]        now_ms_i,
  input  logic [rpdf_pkg::ID_W-1:0]         sender_id_i,
  input  logic [rpdf_pkg::ID_W-1:0]         receiver_addr_i,
  input  logic [rpdf_pkg::ID_W-1:0]         pkt_type_i,
  input  logic [rpdf_pkg::STAMP_W-1:0]      stamp_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              for_me_o,
  output logic                              duplicate_o,
  output logic                              accepted_o,
  output logic                              expired_o,
  output logic [rpdf_pkg::HELD_OUT_W-1:0]   entries_held_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

  // config registers
  logic [rpdf_pkg::ID_W-1:0]  self_id_q;
  logic [rpdf_pkg::ID_W-1:0]  bcast_q;
  logic [rpdf_pkg::GAP_W-1:0] expire_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_id_q <= rpdf_pkg::SELF_ID_RST;
      bcast_q   <= rpdf_pkg::BCAST_RST;
      expire_q  <= rpdf_pkg::EXPIRE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rpdf_pkg::CFG_SELF_ID: self_id_q <= cfg_data_i[rpdf_pkg::ID_W-1:0];
        rpdf_pkg::CFG_BCAST:   bcast_q   <= cfg_data_i[rpdf_pkg::ID_W-1:0];
        rpdf_pkg::CFG_EXPIRE:  expire_q  <= cfg_data_i;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // sequencer and ring state
  rpdf_pkg::rpdf_state_e state_q, state_d;

  logic [CNT_W-1:0]             held_q, held_d;
  logic [IDX_W-1:0]             wslot_q, wslot_d;
  logic [rpdf_pkg::NOW_W-1:0]   last_q, last_d;
  logic [IDX_W-1:0]             ptr_q, ptr_d;
  logic [CNT_W-1:0]             iss_q, iss_d;
  logic [CNT_W-1:0]             cmp_q, cmp_d;
  logic                         rvld_q, rvld_d;
  logic                         for_me_q, for_me_d;
  logic                         dup_q, dup_d;
  logic                         acc_q, acc_d;
  logic                         exp_q, exp_d;
  logic                         out_valid_q, out_valid_d;

  // captured header (payload, no reset)
  logic [rpdf_pkg::NOW_W-1:0]   now_q;
  logic [rpdf_pkg::ID_W-1:0]    rcv_q;
  logic [rpdf_pkg::KEY_W-1:0]   key_q;

  // output payload
  logic                          o_for_me_q, o_dup_q, o_acc_q, o_exp_q;
  logic [rpdf_pkg::HELD_OUT_W-1:0] o_held_q;

  logic in_take;
  logic out_load;

  // store port
  logic                        mem_we, mem_re;
  logic [rpdf_pkg::KEY_W-1:0]  mem_rdata;

  rpdf_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (wslot_q),
    .wr_data_i (key_q),
    .rd_en_i   (mem_re),
    .rd_addr_i (ptr_q),
    .rd_data_o (mem_rdata)
  );

  // shared datapath pieces
  logic [rpdf_pkg::NOW_W-1:0] gap;
  logic [SUM_W-1:0]           oldest_sum;
  logic [IDX_W-1:0]           oldest_idx;
  logic [CNT_W+rpdf_pkg::HELD_OUT_W-1:0] held_ext;

  assign gap        = now_q - last_q;
  assign oldest_sum = SUM_W'(wslot_q) + DEPTH_SUM - SUM_W'(held_q);
  assign oldest_idx = (oldest_sum >= DEPTH_SUM) ? IDX_W'(oldest_sum - DEPTH_SUM)
                                               : IDX_W'(oldest_sum);
  assign held_ext   = {{rpdf_pkg::HELD_OUT_W{1'b0}}, held_q};

  assign in_stall_o = (state_q != rpdf_pkg::ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    wslot_d     = wslot_q;
    last_d      = last_q;
    ptr_d       = ptr_q;
    iss_d       = iss_q;
    cmp_d       = cmp_q;
    rvld_d      = 1'b0;
    for_me_d    = for_me_q;
    dup_d       = dup_q;
    acc_d       = acc_q;
    exp_d       = exp_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      rpdf_pkg::ST_IDLE: begin
        if (in_take) begin
          state_d = rpdf_pkg::ST_GAP;
        end
      end
      rpdf_pkg::ST_GAP: begin
        // gap rule, then address check
        exp_d = 1'b0;
        dup_d = 1'b0;
        acc_d = 1'b0;
        if ((gap > {{(rpdf_pkg::NOW_W-rpdf_pkg::GAP_W){1'b0}}, expire_q}) &&
            (held_q != '0)) begin
          held_d = held_q - CNT_W'(1);
          exp_d  = 1'b1;
        end
        last_d   = now_q;
        for_me_d = (rcv_q == self_id_q) || (rcv_q == bcast_q);
        state_d  = rpdf_pkg::ST_LOCATE;
      end
      rpdf_pkg::ST_LOCATE: begin
        ptr_d = oldest_idx;
        iss_d = '0;
        cmp_d = '0;
        if (!for_me_q) begin
          state_d = rpdf_pkg::ST_RESULT;
        end else if (held_q == '0) begin
          state_d = rpdf_pkg::ST_STORE;
        end else begin
          state_d = rpdf_pkg::ST_SCAN;
        end
      end
      rpdf_pkg::ST_SCAN: begin
        // a read issued here is compared in the cycle after, against the registered read data
        if (iss_q != held_q) begin
          mem_re = 1'b1;
          rvld_d = 1'b1;
          iss_d  = iss_q + CNT_W'(1);
          ptr_d  = (ptr_q == LAST_IDX) ? '0 : ptr_q + IDX_W'(1);
        end
        if (rvld_q) begin
          cmp_d = cmp_q + CNT_W'(1);
          if (mem_rdata == key_q) begin
            dup_d   = 1'b1;
            state_d = rpdf_pkg::ST_RESULT;
          end else if ((cmp_q + CNT_W'(1)) == held_q) begin
            state_d = rpdf_pkg::ST_STORE;
          end
        end
      end
      rpdf_pkg::ST_STORE: begin
        mem_we  = 1'b1;
        wslot_d = (wslot_q == LAST_IDX) ? '0 : wslot_q + IDX_W'(1);
        if (held_q != DEPTH_CNT) begin
          held_d = held_q + CNT_W'(1);
        end
        acc_d   = 1'b1;
        state_d = rpdf_pkg::ST_RESULT;
      end
      rpdf_pkg::ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = rpdf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rpdf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpdf_pkg::ST_IDLE;
      held_q      <= '0;
      wslot_q     <= '0;
      last_q      <= '0;
      ptr_q       <= '0;
      iss_q       <= '0;
      cmp_q       <= '0;
      rvld_q      <= 1'b0;
      for_me_q    <= 1'b0;
      dup_q       <= 1'b0;
      acc_q       <= 1'b0;
      exp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      wslot_q     <= wslot_d;
      last_q      <= last_d;
      ptr_q       <= ptr_d;
      iss_q       <= iss_d;
      cmp_q       <= cmp_d;
      rvld_q      <= rvld_d;
      for_me_q    <= for_me_d;
      dup_q       <= dup_d;
      acc_q       <= acc_d;
      exp_q       <= exp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // header capture; key packs sender, type, stamp
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q <= now_ms_i;
      rcv_q <= receiver_addr_i;
      key_q <= {sender_id_i, pkt_type_i, stamp_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_for_me_q <= for_me_q;
      o_dup_q    <= dup_q;
      o_acc_q    <= acc_q;
      o_exp_q    <= exp_q;
      o_held_q   <= held_ext[rpdf_pkg::HELD_OUT_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign for_me_o       = o_for_me_q;
  assign duplicate_o    = o_dup_q;
  assign accepted_o     = o_acc_q;
  assign expired_o      = o_exp_q;
  assign entries_held_o = o_held_q;

endmodule

>>> tb/sv/tb_recent_packet_duplicate_filter.sv
`timescale 1ns / 100ps
// Self-checking testbench for recent_packet_duplicate_filter: a directed table, then random
// packet headers, scored against an in-bench model of the duplicate ring or a typed row's verdict.
// Depends on rpdf_pkg and the filter RTL only.
module tb_recent_packet_duplicate_filter;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned SLOT_W        = $clog2(DEPTH);
  localparam int unsigned RAND_ITEMS    = 650;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned HISTORY       = 24;    // recent triples kept for resends
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = DEPTH + 10;
  localparam int unsigned QUIET_LIMIT   = 4000;  // cycles with no transaction at all

  typedef struct packed {
    logic [rpdf_pkg::NOW_W-1:0]   now_ms;
    logic [rpdf_pkg::ID_W-1:0]    sender_id;
    logic [rpdf_pkg::ID_W-1:0]    receiver_addr;
    logic [rpdf_pkg::ID_W-1:0]    pkt_type;
    logic [rpdf_pkg::STAMP_W-1:0] stamp;
  } header_t;

  typedef struct packed {
    logic                            for_me;
    logic                            duplicate;
    logic                            accepted;
    logic                            expired;
    logic [rpdf_pkg::HELD_OUT_W-1:0] entries_held;
  } verdict_t;

  // One directed row: header, plus a hand-written verdict where 'typed' is set
  typedef struct packed {
    header_t  hdr;
    logic     typed;
    verdict_t want;
  } dir_row_t;

  localparam verdict_t NO_WANT = '0;

  // Reset config: self 0, broadcast 255, expire gap 1000 ms.
  localparam dir_row_t DIRECTED [25] = '{
    // first packet on an empty ring with a big gap: nothing to drop
    '{'{32'd5000, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 5'd1}},
    // same triple again: duplicate
    '{'{32'd5000, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 5'd1}},
    // all-ones triple via broadcast
    '{'{32'd5010, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF}, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 5'd2}},
    // not addressed to us: ring untouched
    '{'{32'd5020, 8'h12, 8'h5A, 8'h34, 16'h1234}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 5'd2}},
    // gap exactly at the limit: no drop
    '{'{32'd6020, 8'h01, 8'h00, 8'h02, 16'h0003}, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 5'd3}},
    // gap one past the limit: oldest dropped, then store
    '{'{32'd7021, 8'h02, 8'hFF, 8'h03, 16'h0004}, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b1, 5'd3}},
    // clock runs backwards -> huge gap, drop, not for us
    '{'{32'd0,    8'h77, 8'h77, 8'h77, 16'h7777}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 5'd2}},
    // dropped triples must not match any more
    '{'{32'd0,    8'h00, 8'hFF, 8'h00, 16'h0000}, 1'b0, NO_WANT},
    '{'{32'hFFFF_FFFF, 8'hFF, 8'h00, 8'hFF, 16'hFFFF}, 1'b0, NO_WANT},
    // fill the ring past DEPTH so the oldest gets overwritten
    '{'{32'd10,  8'h10, 8'h00, 8'h00, 16'h0100}, 1'b0, NO_WANT},
    '{'{32'd20,  8'h11, 8'hFF, 8'h01, 16'h8000}, 1'b0, NO_WANT},
    '{'{32'd30,  8'h12, 8'h00, 8'h02, 16'h0102}, 1'b0, NO_WANT},
    '{'{32'd40,  8'h13, 8'hFF, 8'h03, 16'h0103}, 1'b0, NO_WANT},
    '{'{32'd50,  8'h14, 8'h00, 8'h04, 16'h0104}, 1'b0, NO_WANT},
    '{'{32'd60,  8'h15, 8'hFF, 8'h05, 16'h0105}, 1'b0, NO_WANT},
    '{'{32'd70,  8'h16, 8'h00, 8'h06, 16'h0106}, 1'b0, NO_WANT},
    '{'{32'd80,  8'h17, 8'hFF, 8'h07, 16'h0107}, 1'b0, NO_WANT},
    '{'{32'd90,  8'h18, 8'h00, 8'h08, 16'h0108}, 1'b0, NO_WANT},
    '{'{32'd100, 8'h19, 8'hFF, 8'h09, 16'h0109}, 1'b0, NO_WANT},
    '{'{32'd110, 8'h1A, 8'h00, 8'h0A, 16'h010A}, 1'b0, NO_WANT},
    '{'{32'd120, 8'h1B, 8'hFF, 8'h0B, 16'h010B}, 1'b0, NO_WANT},
    '{'{32'd130, 8'h1C, 8'h00, 8'h0C, 16'h010C}, 1'b0, NO_WANT},
    '{'{32'd140, 8'h1D, 8'hFF, 8'h0D, 16'h010D}, 1'b0, NO_WANT},
    '{'{32'd150, 8'h1E, 8'h00, 8'h0E, 16'h010E}, 1'b0, NO_WANT},
    // newest entry of a full ring is still found
    '{'{32'd160, 8'h1E, 8'h00, 8'h0E, 16'h010E}, 1'b0, NO_WANT}
  };

  // DUT ports; the inputs are at known values from time zero
  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            cfg_we_i        = 1'b0;
  logic [rpdf_pkg::CFG_IDX_W-1:0]  cfg_idx_i       = rpdf_pkg::CFG_SELF_ID;
  logic [rpdf_pkg::CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                            in_valid_i      = 1'b0;
  logic                            in_stall_o;
  logic [rpdf_pkg::NOW_W-1:0]      now_ms_i        = '0;
  logic [rpdf_pkg::ID_W-1:0]       sender_id_i     = '0;
  logic [rpdf_pkg::ID_W-1:0]       receiver_addr_i = '0;
  logic [rpdf_pkg::ID_W-1:0]       pkt_type_i      = '0;
  logic [rpdf_pkg::STAMP_W-1:0]    stamp_i         = '0;
  logic                            out_valid_o;
  logic                            out_stall_i     = 1'b0;
  logic                            for_me_o;
  logic                            duplicate_o;
  logic                            accepted_o;
  logic                            expired_o;
  logic [rpdf_pkg::HELD_OUT_W-1:0] entries_held_o;

  // Travels with the payload so the input monitor knows about a typed verdict
  logic     row_typed = 1'b0;
  verdict_t row_want  = '0;

  // Pacing knobs
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_seq       = 0;
  int hold_done      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int mismatch_count = 0;

  // Shadow of the filter: config, ring, write slot, fill level, last arrival
  logic [rpdf_pkg::ID_W-1:0]  self_addr    = rpdf_pkg::SELF_ID_RST;
  logic [rpdf_pkg::ID_W-1:0]  bcast_addr   = rpdf_pkg::BCAST_RST;
  logic [rpdf_pkg::GAP_W-1:0] expire_gap   = rpdf_pkg::EXPIRE_RST;
  logic [rpdf_pkg::KEY_W-1:0] ring [DEPTH];
  logic [SLOT_W-1:0]          wr_slot      = '0;
  int                         held         = 0;
  logic [rpdf_pkg::NOW_W-1:0] last_arrival = '0;

  verdict_t verdict_q [$];   // verdicts still owed by the DUT, oldest first

  recent_packet_duplicate_filter #(.DEPTH(DEPTH)) uut (.*);

  always #6 clk_i = ~clk_i;

  // Gap rule, then lookup and store, exactly one verdict per header.
  function automatic verdict_t filter_packet(header_t h);
    verdict_t                   v;
    logic [rpdf_pkg::KEY_W-1:0] key;
    logic [rpdf_pkg::NOW_W-1:0] gap;
    logic [SLOT_W-1:0]          oldest;
    v   = '0;
    key = {h.sender_id, h.pkt_type, h.stamp};
    // modulo 2^32 difference: a clock that goes back reads as a huge gap
    gap = h.now_ms - last_arrival;
    if (gap > rpdf_pkg::NOW_W'(expire_gap) && held > 0) begin
      held--;
      v.expired = 1'b1;
    end
    last_arrival = h.now_ms;
    v.for_me = (h.receiver_addr == self_addr) || (h.receiver_addr == bcast_addr);
    if (v.for_me) begin
      oldest = wr_slot - SLOT_W'(held);
      for (int i = 0; i < held; i++) begin
        if (ring[SLOT_W'(oldest + i)] == key) v.duplicate = 1'b1;
      end
      if (!v.duplicate) begin
        // a full ring overwrites its oldest entry and stays full
        ring[wr_slot] = key;
        wr_slot++;
        if (held < DEPTH) held++;
        v.accepted = 1'b1;
      end
    end
    v.entries_held = rpdf_pkg::HELD_OUT_W'(held);
    return v;
  endfunction

  // Input side: track config writes and predict each accepted header.
  always @(posedge clk_i) begin
    verdict_t v;
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        rpdf_pkg::CFG_SELF_ID: self_addr  = cfg_data_i[rpdf_pkg::ID_W-1:0];
        rpdf_pkg::CFG_BCAST:   bcast_addr = cfg_data_i[rpdf_pkg::ID_W-1:0];
        rpdf_pkg::CFG_EXPIRE:  expire_gap = cfg_data_i[rpdf_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      v = filter_packet({now_ms_i, sender_id_i, receiver_addr_i, pkt_type_i, stamp_i});
      // typed rows are scored against the hand-written verdict; shadow still advances
      verdict_q.push_back(row_typed ? row_want : v);
    end
  end

  task automatic check_verdict(verdict_t want, verdict_t got);
    if (got.for_me != want.for_me) begin
      $error("for_me: expected %0d, got %0d", want.for_me, got.for_me);
      mismatch_count++;
    end
    if (got.duplicate != want.duplicate) begin
      $error("duplicate: expected %0d, got %0d", want.duplicate, got.duplicate);
      mismatch_count++;
    end
    if (got.accepted != want.accepted) begin
      $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
      mismatch_count++;
    end
    if (got.expired != want.expired) begin
      $error("expired: expected %0d, got %0d", want.expired, got.expired);
      mismatch_count++;
    end
    if (got.entries_held != want.entries_held) begin
      $error("entries_held: expected %0d, got %0d", want.entries_held, got.entries_held);
      mismatch_count++;
    end
  endtask

  // Output side: each result transaction against the oldest owed verdict.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $error("result transaction with no header outstanding");
        mismatch_count++;
      end else begin
        check_verdict(verdict_q.pop_front(),
                      {for_me_o, duplicate_o, accepted_o, expired_o, entries_held_o});
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so the
  // output register and the sequencer back up into the input.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_seq != hold_done) begin
      hold_done   <= hold_seq;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: any transaction on either channel resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Offer one header, with random idle cycles ahead of it; returns on the
  // edge where it is taken. Payload holds while stalled.
  task automatic present(header_t h, logic typed, verdict_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    now_ms_i        <= h.now_ms;
    sender_id_i     <= h.sender_id;
    receiver_addr_i <= h.receiver_addr;
    pkt_type_i      <= h.pkt_type;
    stamp_i         <= h.stamp;
    row_typed       <= typed;
    row_want        <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop offering, wait for every owed verdict, then let the sequencer settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Three back-to-back register writes; upper data bits of the 8-bit
  // registers carry junk the block must ignore.
  task automatic program_filter(logic [rpdf_pkg::ID_W-1:0] self_id,
                                logic [rpdf_pkg::ID_W-1:0] bcast,
                                logic [rpdf_pkg::GAP_W-1:0] gap_ms);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= rpdf_pkg::CFG_SELF_ID;
    cfg_data_i <= {8'($urandom), self_id};
    @(posedge clk_i);
    cfg_idx_i  <= rpdf_pkg::CFG_BCAST;
    cfg_data_i <= {8'($urandom), bcast};
    @(posedge clk_i);
    cfg_idx_i  <= rpdf_pkg::CFG_EXPIRE;
    cfg_data_i <= gap_ms;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    header_t                    h;
    logic [rpdf_pkg::ID_W-1:0]  p_self, p_bcast;
    logic [rpdf_pkg::GAP_W-1:0] p_gap;
    logic [rpdf_pkg::NOW_W-1:0] clock_ms;
    logic [rpdf_pkg::KEY_W-1:0] key;
    logic [rpdf_pkg::KEY_W-1:0] recent [$];
    int                         item_no, roll, mode;

    clock_ms = '0;
    item_no  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under reset config
    send_gap_pct   = 10;
    recv_stall_pct = 73;
    foreach (DIRECTED[r]) present(DIRECTED[r].hdr, DIRECTED[r].typed, DIRECTED[r].want);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin p_self = 8'h3C; p_bcast = 8'hFF; p_gap = 16'd0; end     // every nonzero gap expires
        1: begin p_self = 8'hFF; p_bcast = 8'h00; p_gap = 16'hFFFF; end  // widest gap
        2: begin p_self = 8'h00; p_bcast = 8'h00; p_gap = 16'd50; end    // self == broadcast
        3: begin
          p_self  = 8'($urandom);
          p_bcast = 8'($urandom);
          p_gap   = 16'($urandom_range(2000));
        end
        default: begin p_self = 8'($urandom); p_bcast = 8'hA5; p_gap = 16'd1000; end
      endcase
      program_filter(p_self, p_bcast, p_gap);
      // long receiver hold-off while headers keep coming
      if (p == 1) hold_seq <= hold_seq + 1;

      for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
        // receiver stalls first, then sender idles, then neither
        mode = item_no * 3 / RAND_ITEMS;
        send_gap_pct   = (mode == 0) ? 10 : (mode == 1) ? 73 : 0;
        recv_stall_pct = (mode == 0) ? 73 : (mode == 1) ? 10 : 0;

        // arrival time: repeats, at or just past the limit, arbitrary jumps
        // (backwards too), and ordinary spacing around the limit
        roll = $urandom_range(99);
        if (roll < 10) clock_ms += 0;
        else if (roll < 20) clock_ms += rpdf_pkg::NOW_W'(p_gap) + $urandom_range(1);
        else if (roll < 28) clock_ms += $urandom;
        else clock_ms += $urandom_range(2 * p_gap + 2);

        // a resend of a recent triple, or a fresh one with fields often from a small id space
        if (recent.size() != 0 && $urandom_range(99) < 40) begin
          key = recent[$urandom_range(recent.size() - 1)];
        end else begin
          key[31:24] = ($urandom_range(1) != 0) ? 8'($urandom_range(7)) : 8'($urandom);
          key[23:16] = ($urandom_range(1) != 0) ? 8'($urandom_range(3)) : 8'($urandom);
          key[15:0]  = ($urandom_range(1) != 0) ? 16'($urandom_range(15)) : 16'($urandom);
          recent.push_back(key);
          if (recent.size() > HISTORY) void'(recent.pop_front());
        end

        h.now_ms    = clock_ms;
        h.sender_id = key[31:24];
        h.pkt_type  = key[23:16];
        h.stamp     = key[15:0];
        roll = $urandom_range(99);
        h.receiver_addr = (roll < 40) ? p_self : (roll < 70) ? p_bcast : 8'($urandom);

        present(h, 1'b0, NO_WANT);
        item_no++;
      end
      drain();
    end

    if (verdict_q.size() != 0) begin
      $error("%0d verdicts never arrived", verdict_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
